// ----- src/hch_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hch_pkg
// Shared sizes, opcodes, controller/datapath bundles and helper functions
// for the HSV color histogram unit.
// ----------------------------------------------------------------------------
package hch_pkg;

  // Histogram geometry
  localparam int LEVELS      = 16;
  localparam int COUNT_WIDTH = 16;
  localparam int LVL_W       = $clog2(LEVELS);
  localparam int NUM_BINS    = LEVELS * LEVELS * LEVELS;
  localparam int BIN_W       = $clog2(NUM_BINS);
  localparam int PROD_W      = 8 + LVL_W + 1;

  // Port field widths
  localparam int OPCODE_W = 2;
  localparam int CHAN_W   = 8;
  localparam int INDEX_W  = 12;
  localparam int OUT_W    = 16;

  // Width for range compares of the read index
  localparam int CMP_W = ((BIN_W > INDEX_W) ? BIN_W : INDEX_W) + 1;
  // Width for saturating a count onto the output field
  localparam int SAT_W = (COUNT_WIDTH > OUT_W) ? COUNT_WIDTH : OUT_W;

  localparam logic [OPCODE_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_CLEAR = 2'd2;

  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};
  localparam logic [BIN_W-1:0]       BIN_LAST  = BIN_W'(NUM_BINS - 1);

  typedef logic [COUNT_WIDTH-1:0] count_t;
  typedef logic [BIN_W-1:0]       bin_addr_t;

  // Controller -> datapath
  typedef struct packed {
    logic load;      // capture item fields
    logic sel_read;  // item is a bin read (else a pixel add)
    logic mem_rd;    // read the addressed bin
    logic mem_inc;   // write back the incremented count
    logic clr_init;  // restart the clear sweep
    logic clr_wr;    // zero one bin of the sweep
  } hch_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic clr_last;  // sweep is at the last bin
  } hch_sts_t;

  // level = byte * LEVELS / 256
  function automatic logic [LVL_W-1:0] quantize(input logic [CHAN_W-1:0] b);
    logic [PROD_W-1:0] p;
    p = PROD_W'(b) * PROD_W'(LEVELS);
    return p[8 +: LVL_W];
  endfunction

  function automatic bin_addr_t pixel_bin(input logic [CHAN_W-1:0] h,
                                          input logic [CHAN_W-1:0] s,
                                          input logic [CHAN_W-1:0] v);
    bin_addr_t hs;
    hs = BIN_W'(quantize(h)) * BIN_W'(LEVELS) + BIN_W'(quantize(s));
    return hs * BIN_W'(LEVELS) + BIN_W'(quantize(v));
  endfunction

  function automatic bin_addr_t index_to_addr(input logic [INDEX_W-1:0] idx);
    logic [CMP_W-1:0] w;
    w = CMP_W'(idx);
    return w[BIN_W-1:0];
  endfunction

  function automatic logic index_in_range(input logic [INDEX_W-1:0] idx);
    return CMP_W'(idx) < CMP_W'(NUM_BINS);
  endfunction

  function automatic logic [OUT_W-1:0] count_to_out(input count_t c);
    logic [SAT_W-1:0] w;
    w = SAT_W'(c);
    if (w > SAT_W'({OUT_W{1'b1}})) begin
      return {OUT_W{1'b1}};
    end
    return w[OUT_W-1:0];
  endfunction

endpackage

// ----- src/hch_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hch_ctrl
// Sequencer: clear sweep, bin read, increment/readout and item acceptance.
// ----------------------------------------------------------------------------
module hch_ctrl (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [hch_pkg::OPCODE_W-1:0] opcode,
  input  hch_pkg::hch_sts_t        sts,
  output hch_pkg::hch_cmd_t        cmd,
  output logic                     busy,
  output logic                     result_valid
);
  import hch_pkg::*;

  localparam logic [1:0] ST_CLEAR  = 2'd0;
  localparam logic [1:0] ST_IDLE   = 2'd1;
  localparam logic [1:0] ST_READ   = 2'd2;
  localparam logic [1:0] ST_UPDATE = 2'd3;

  logic [1:0] state, state_next;
  logic       rd_pend, rd_pend_next;
  logic       accept;

  assign busy   = (state == ST_CLEAR) || (state == ST_READ);
  assign accept = start && !busy;

  always_comb begin
    state_next   = state;
    rd_pend_next = rd_pend;
    cmd          = '0;
    result_valid = 1'b0;
    case (state)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        cmd.mem_rd = 1'b1;
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.mem_inc  = !rd_pend;
        result_valid = rd_pend;
        state_next   = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    // new item may enter in idle or in the write-back cycle
    if (accept) begin
      case (opcode)
        OP_ADD: begin
          cmd.load     = 1'b1;
          rd_pend_next = 1'b0;
          state_next   = ST_READ;
        end
        OP_READ: begin
          cmd.load     = 1'b1;
          cmd.sel_read = 1'b1;
          rd_pend_next = 1'b1;
          state_next   = ST_READ;
        end
        OP_CLEAR: begin
          cmd.clr_init = 1'b1;
          state_next   = ST_CLEAR;
        end
        default: begin
          state_next = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= rd_pend_next;
    end
  end

endmodule

// ----- src/hch_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hch_datapath
// Bin store, address capture, saturating increment and clear sweep counter.
// ----------------------------------------------------------------------------
module hch_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  hch_pkg::hch_cmd_t           cmd,
  input  logic [hch_pkg::CHAN_W-1:0]  hue,
  input  logic [hch_pkg::CHAN_W-1:0]  saturation,
  input  logic [hch_pkg::CHAN_W-1:0]  value_level,
  input  logic [hch_pkg::INDEX_W-1:0] bin_index,
  output hch_pkg::hch_sts_t           sts,
  output logic [hch_pkg::OUT_W-1:0]   bin_count,
  output logic [hch_pkg::INDEX_W-1:0] bin_echo
);
  import hch_pkg::*;

  count_t              mem [NUM_BINS];
  bin_addr_t           addr;
  logic [INDEX_W-1:0]  rd_index;
  logic                in_range;
  count_t              rd_data;
  bin_addr_t           clr_cnt;

  logic                wr_en;
  bin_addr_t           wr_addr;
  count_t              wr_data;

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      addr     <= cmd.sel_read ? index_to_addr(bin_index)
                               : pixel_bin(hue, saturation, value_level);
      rd_index <= bin_index;
      in_range <= index_in_range(bin_index);
    end
  end

  // clear sweep
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_init) begin
      clr_cnt <= '0;
    end else if (cmd.clr_wr) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  assign sts.clr_last = (clr_cnt == BIN_LAST);

  // single write port: sweep zeroes, or saturating increment
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = addr;
    wr_data = rd_data + 1'b1;
    if (cmd.clr_wr) begin
      wr_en   = 1'b1;
      wr_addr = clr_cnt;
      wr_data = '0;
    end else if (cmd.mem_inc && (rd_data != COUNT_MAX)) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.mem_rd) begin
      rd_data <= mem[addr];
    end
  end

  assign bin_count = in_range ? count_to_out(rd_data) : '0;
  assign bin_echo  = rd_index;

endmodule

// ----- src/hsv_color_histogram_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_color_histogram_unit
// Joint 16x16x16 hue/saturation/value histogram with saturating 16-bit bins.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. Add (opcode 0)
// quantizes each channel to its top four bits and bumps bin h*256+s*16+v;
// read (opcode 1) returns one bin; clear (opcode 2) zeroes all bins;
// opcode 3 is taken and ignored. Add and read each pass through the item
// edge, then a busy cycle that reads the bin store's single registered
// read port. The cycle after that, add writes back the incremented count
// while read shows its result; busy is already low then, so the next item
// can be taken in that cycle (the write lands before its read). A read
// result sits on bin_count/bin_echo for exactly one cycle with result_valid
// high; there is no back-pressure, so the receiver must take it then. Clear
// walks the store one bin per cycle, busy until the last bin is zeroed;
// the same sweep runs after reset, so the block first accepts an item once
// it ends. A read of an index past the store returns a count of 0.
// ----------------------------------------------------------------------------
module hsv_color_histogram_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [hch_pkg::OPCODE_W-1:0]  opcode,
  input  logic [hch_pkg::CHAN_W-1:0]    hue,
  input  logic [hch_pkg::CHAN_W-1:0]    saturation,
  input  logic [hch_pkg::CHAN_W-1:0]    value_level,
  input  logic [hch_pkg::INDEX_W-1:0]   bin_index,
  output logic                          result_valid,
  output logic [hch_pkg::OUT_W-1:0]     bin_count,
  output logic [hch_pkg::INDEX_W-1:0]   bin_echo
);
  import hch_pkg::*;

  hch_cmd_t cmd;
  hch_sts_t sts;

  // sequencer: owns handshake, clear sweep pacing and result strobe
  hch_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .opcode       (opcode),
    .sts          (sts),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid)
  );

  // bin store and arithmetic
  hch_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .hue         (hue),
    .saturation  (saturation),
    .value_level (value_level),
    .bin_index   (bin_index),
    .sts         (sts),
    .bin_count   (bin_count),
    .bin_echo    (bin_echo)
  );

endmodule

// ----- src/hch_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hch_checker
// Port-level timing checks for the histogram unit, bound to the top level.
// ----------------------------------------------------------------------------
module hch_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          start,
  input logic                          busy,
  input logic [hch_pkg::OPCODE_W-1:0]  opcode,
  input logic [hch_pkg::INDEX_W-1:0]   bin_index,
  input logic                          result_valid,
  input logic [hch_pkg::INDEX_W-1:0]   bin_echo
);
  import hch_pkg::*;

  // store is swept after reset
  a_reset_sweep: assert property (@(posedge clk) rst |=> busy)
    else $error("not busy after reset");

  // a result only ever follows an accepted read item
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(start && !busy && (opcode == OP_READ), 2))
    else $error("result without a read item");

  a_echo: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (bin_echo == $past(bin_index, 2)))
    else $error("echoed index mismatch");

  a_rmw_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && ((opcode == OP_ADD) || (opcode == OP_READ))) |=> busy)
    else $error("bin access cycle not busy");

  a_clear_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (opcode == OP_CLEAR)) |=> (busy && !result_valid))
    else $error("clear sweep not started");

endmodule

bind hsv_color_histogram_unit hch_checker u_hch_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .opcode       (opcode),
  .bin_index    (bin_index),
  .result_valid (result_valid),
  .bin_echo     (bin_echo)
);
